// ===== sv/assert_macros.svh =====
// assertion macros used by the lru stack distance counter
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/lsd_pkg.sv =====
// field widths, payload types and status codes of the lru stack distance counter
// no dependencies
package lsd_pkg;

    localparam int ITEM_W   = 11;
    localparam int ABOVE_W  = 10;
    localparam int STATUS_W = 2;
    localparam int ITEM_MAX = (1 << ITEM_W) - 1;

    typedef logic [ITEM_W-1:0]   item_t;
    typedef logic [ABOVE_W-1:0]  above_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_RANGE = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

// ===== sv/lsd_stamp_ram.sv =====
// per-item stamp memory: one write port, one registered read port
// no dependencies
module lsd_stamp_ram #(
    parameter int DEPTH = 1024,
    parameter int DW    = 11
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lsd_tree_ram.sv =====
// count tree memory: one write port, two registered read ports
// a read of the address being written returns the new data; no dependencies
module lsd_tree_ram #(
    parameter int DEPTH = 4096,
    parameter int DW    = 11
) (
    input  logic                     clk,
    input  logic                     rd_a_en,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [DW-1:0]            rd_a_data,
    input  logic                     rd_b_en,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [DW-1:0]            rd_b_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            if (wr_en && (wr_addr == rd_a_addr)) begin
                rd_a_reg <= wr_data;
            end else begin
                rd_a_reg <= mem[rd_a_addr];
            end
        end
        if (rd_b_en) begin
            if (wr_en && (wr_addr == rd_b_addr)) begin
                rd_b_reg <= wr_data;
            end else begin
                rd_b_reg <= mem[rd_b_addr];
            end
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ===== sv/lru_stack_distance_counter.sv =====
// LRU stack distance counter. Each input beat names an item; the result beat gives the
// number of items above it in the recency stack (then the item moves to the top) and a
// status. After reset and after every item_count write the block rebuilds its memories
// with s_ready low; configuration writes are still taken and restart the rebuild. An
// item out of range or past the access capacity skips the lookup and goes straight to
// the emit state. A normal access runs a stamp lookup, a range sum that climbs the tree
// one level a cycle, then up to two walks from leaf to root that share the single write
// port of the count tree memory.
`include "assert_macros.svh"

module lru_stack_distance_counter #(
    parameter int MAX_ITEMS    = 1024,
    parameter int MAX_ACCESSES = 1024,
    parameter int TREE_LEAVES  = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  lsd_pkg::item_t    cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  lsd_pkg::item_t    s_item_id,
    output logic              m_valid,
    input  logic              m_ready,
    output lsd_pkg::above_t   m_items_above,
    output lsd_pkg::status_t  m_status
);
    import lsd_pkg::*;

    localparam int SA_W       = $clog2(MAX_ITEMS);
    localparam int LEAF_W     = $clog2(MAX_ACCESSES + MAX_ITEMS + 1);
    localparam int NODE_W     = $clog2(2 * TREE_LEAVES);
    localparam int QW         = NODE_W + 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int ACC_W      = $clog2(MAX_ACCESSES + 1);
    localparam int SWEEP_LEN  = (2 * TREE_LEAVES > MAX_ITEMS + 1) ? 2 * TREE_LEAVES
                                                                  : MAX_ITEMS + 1;
    localparam int SW_W       = $clog2(SWEEP_LEN);
    localparam int CMP_W      = ((NODE_W > LEAF_W) ? NODE_W : LEAF_W) + 2;
    localparam int INIT_COUNT = (MAX_ITEMS > ITEM_MAX) ? ITEM_MAX : MAX_ITEMS;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOOKUP  = 3'd1;
    localparam logic [2:0] ST_QUERY   = 3'd2;
    localparam logic [2:0] ST_WALK_RD = 3'd3;
    localparam logic [2:0] ST_WALK_WR = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;
    localparam logic [2:0] ST_EMIT    = 3'd6;

    logic [2:0]        state_reg, state_next;
    item_t             item_count_reg, item_count_next;
    logic              sweep_reg, sweep_next;
    logic [SW_W-1:0]   sw_cnt_reg, sw_cnt_next;
    logic              sw_wr_vld_reg, sw_wr_vld_next;
    logic [NODE_W-1:0] sw_wr_node_reg, sw_wr_node_next;
    logic              sw_wr_leaf_reg, sw_wr_leaf_next;
    logic              sw_wr_bit_reg, sw_wr_bit_next;
    logic [ACC_W-1:0]  acc_cnt_reg, acc_cnt_next;
    item_t             id_reg, id_next;
    logic [LEAF_W-1:0] old_leaf_reg, old_leaf_next;
    logic [QW-1:0]     lo_reg, lo_next;
    logic [QW-1:0]     hi_reg, hi_next;
    logic              qa_reg, qa_next;
    logic              qb_reg, qb_next;
    logic [CNT_W-1:0]  sum_reg, sum_next;
    logic [NODE_W-1:0] walk_node_reg, walk_node_next;
    logic              walk_inc_reg, walk_inc_next;
    above_t            res_above_reg, res_above_next;
    status_t           res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    above_t            m_above_reg, m_above_next;
    status_t           m_status_reg, m_status_next;

    // memory port signals
    logic              ta_en, tb_en, tw_en;
    logic [NODE_W-1:0] ta_addr, tb_addr, tw_addr;
    logic [CNT_W-1:0]  ta_data, tb_data, tw_data;
    logic              st_re, st_we;
    logic [SA_W-1:0]   st_raddr, st_waddr;
    logic [LEAF_W-1:0] st_rdata, st_wdata;

    // helpers
    logic              busy, s_accept, id_bad, cap_full, cfg_hit_max;
    item_t             cfg_val;
    logic [CMP_W-1:0]  sw_node_x, sw_leaf_x;
    logic [NODE_W-1:0] sw_node;
    logic              sw_node_ok, sw_is_leaf, sw_bit, sw_stamp_ok;
    logic [LEAF_W-1:0] new_leaf;
    logic [CMP_W-1:0]  new_node_x, old_node_x, old_x, old_c;
    logic              new_in_tree, old_in_tree, q_go, at_root;
    logic [CNT_W-1:0]  walk_upd;

    assign busy     = sweep_reg || sw_wr_vld_reg;
    assign s_ready  = (state_reg == ST_IDLE) && !busy;
    assign s_accept = s_valid && s_ready;
    assign id_bad   = (s_item_id == '0) || (s_item_id > item_count_reg);
    assign cap_full = acc_cnt_reg >= ACC_W'(MAX_ACCESSES);

    assign cfg_hit_max = 32'(cfg_wr_data) > MAX_ITEMS;
    assign cfg_val     = (cfg_wr_data == '0) ? ITEM_W'(1)
                       : (cfg_hit_max ? ITEM_W'(MAX_ITEMS) : cfg_wr_data);

    // rebuild sweep walks the tree from the last node down to the root
    assign sw_node_x   = CMP_W'(2 * TREE_LEAVES - 1) - CMP_W'(sw_cnt_reg);
    assign sw_node     = sw_node_x[NODE_W-1:0];
    assign sw_node_ok  = sweep_reg && (32'(sw_cnt_reg) < 2 * TREE_LEAVES - 1);
    assign sw_is_leaf  = sw_node_x >= CMP_W'(TREE_LEAVES);
    assign sw_leaf_x   = sw_node_x - CMP_W'(TREE_LEAVES) + CMP_W'(1);
    assign sw_bit      = (sw_leaf_x >= CMP_W'(MAX_ACCESSES + 1))
                      && (sw_leaf_x <= CMP_W'(MAX_ACCESSES) + CMP_W'(item_count_reg));
    assign sw_stamp_ok = sweep_reg && (32'(sw_cnt_reg) < MAX_ITEMS);

    // leaves of this access
    assign new_leaf    = LEAF_W'(MAX_ACCESSES) - LEAF_W'(acc_cnt_reg);
    assign new_in_tree = CMP_W'(new_leaf) <= CMP_W'(TREE_LEAVES);
    assign new_node_x  = CMP_W'(TREE_LEAVES) + CMP_W'(new_leaf) - CMP_W'(1);
    assign old_in_tree = (old_leaf_reg != '0)
                      && (CMP_W'(old_leaf_reg) <= CMP_W'(TREE_LEAVES));
    assign old_node_x  = CMP_W'(TREE_LEAVES) + CMP_W'(old_leaf_reg) - CMP_W'(1);
    assign old_x       = CMP_W'(st_rdata);
    assign old_c       = (old_x > CMP_W'(TREE_LEAVES + 1)) ? CMP_W'(TREE_LEAVES + 1) : old_x;

    assign q_go     = lo_reg < hi_reg;
    assign at_root  = walk_node_reg == NODE_W'(1);
    assign walk_upd = walk_inc_reg ? (ta_data + CNT_W'(1))
                    : ((ta_data == '0) ? '0 : (ta_data - CNT_W'(1)));

    always_comb begin
        state_next      = state_reg;
        item_count_next = item_count_reg;
        sweep_next      = sweep_reg;
        sw_cnt_next     = sw_cnt_reg;
        sw_wr_vld_next  = 1'b0;
        sw_wr_node_next = sw_node;
        sw_wr_leaf_next = sw_is_leaf;
        sw_wr_bit_next  = sw_bit;
        acc_cnt_next    = acc_cnt_reg;
        id_next         = id_reg;
        old_leaf_next   = old_leaf_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        qa_next         = 1'b0;
        qb_next         = 1'b0;
        // range sum data lands in the cycle after its read
        sum_next        = sum_reg + (qa_reg ? ta_data : '0) + (qb_reg ? tb_data : '0);
        walk_node_next  = walk_node_reg;
        walk_inc_next   = walk_inc_reg;
        res_above_next  = res_above_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_above_next    = m_above_reg;
        m_status_next   = m_status_reg;

        ta_en    = 1'b0;
        ta_addr  = walk_node_reg;
        tb_en    = 1'b0;
        tb_addr  = hi_reg[NODE_W-1:0] - NODE_W'(1);
        tw_en    = 1'b0;
        tw_addr  = walk_node_reg;
        tw_data  = walk_upd;
        st_re    = s_accept;
        st_raddr = SA_W'(s_item_id - ITEM_W'(1));
        st_we    = 1'b0;
        st_waddr = SA_W'(id_reg - ITEM_W'(1));
        st_wdata = new_leaf;

        // rebuild sweep
        if (sweep_reg) begin
            if (32'(sw_cnt_reg) == SWEEP_LEN - 1) begin
                sweep_next = 1'b0;
            end else begin
                sw_cnt_next = sw_cnt_reg + SW_W'(1);
            end
            if (sw_node_ok) begin
                sw_wr_vld_next = 1'b1;
                if (!sw_is_leaf) begin
                    ta_en   = 1'b1;
                    ta_addr = sw_node << 1;
                    tb_en   = 1'b1;
                    tb_addr = (sw_node << 1) | NODE_W'(1);
                end
            end
            if (sw_stamp_ok) begin
                st_we    = 1'b1;
                st_waddr = sw_cnt_reg[SA_W-1:0];
                st_wdata = LEAF_W'(MAX_ACCESSES) + LEAF_W'(sw_cnt_reg) + LEAF_W'(1);
            end
        end
        if (sw_wr_vld_reg) begin
            tw_en   = 1'b1;
            tw_addr = sw_wr_node_reg;
            tw_data = sw_wr_leaf_reg ? CNT_W'(sw_wr_bit_reg) : (ta_data + tb_data);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    id_next        = s_item_id;
                    res_above_next = '0;
                    if (id_bad) begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_EMIT;
                    end else if (cap_full) begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_EMIT;
                    end else begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                old_leaf_next = st_rdata;
                lo_next       = QW'(TREE_LEAVES);
                hi_next       = QW'(CMP_W'(TREE_LEAVES) + old_c - CMP_W'(1));
                sum_next      = '0;
                state_next    = ST_QUERY;
            end
            ST_QUERY: begin
                if (q_go) begin
                    ta_en   = lo_reg[0];
                    ta_addr = lo_reg[NODE_W-1:0];
                    tb_en   = hi_reg[0];
                    qa_next = lo_reg[0];
                    qb_next = hi_reg[0];
                    lo_next = (lo_reg + QW'(lo_reg[0])) >> 1;
                    hi_next = hi_reg >> 1;
                end else if (old_in_tree) begin
                    walk_node_next = old_node_x[NODE_W-1:0];
                    walk_inc_next  = 1'b0;
                    state_next     = ST_WALK_RD;
                end else if (new_in_tree) begin
                    walk_node_next = new_node_x[NODE_W-1:0];
                    walk_inc_next  = 1'b1;
                    state_next     = ST_WALK_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_WALK_RD: begin
                ta_en      = 1'b1;
                state_next = ST_WALK_WR;
            end
            ST_WALK_WR: begin
                tw_en = 1'b1;
                if (!at_root) begin
                    // climb: write this node, read its parent
                    ta_en          = 1'b1;
                    ta_addr        = walk_node_reg >> 1;
                    walk_node_next = walk_node_reg >> 1;
                end else if (!walk_inc_reg && new_in_tree) begin
                    walk_node_next = new_node_x[NODE_W-1:0];
                    walk_inc_next  = 1'b1;
                    state_next     = ST_WALK_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                st_we           = 1'b1;
                acc_cnt_next    = acc_cnt_reg + ACC_W'(1);
                res_above_next  = ABOVE_W'(sum_reg);
                res_status_next = STATUS_OK;
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_above_next  = res_above_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // register write sets the item count, clears the access count and restarts the rebuild
        if (cfg_wr_en) begin
            item_count_next = cfg_val;
            sweep_next      = 1'b1;
            sw_cnt_next     = '0;
            acc_cnt_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            item_count_reg <= ITEM_W'(INIT_COUNT);
            sweep_reg      <= 1'b1;
            sw_cnt_reg     <= '0;
            sw_wr_vld_reg  <= 1'b0;
            acc_cnt_reg    <= '0;
            qa_reg         <= 1'b0;
            qb_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            item_count_reg <= item_count_next;
            sweep_reg      <= sweep_next;
            sw_cnt_reg     <= sw_cnt_next;
            sw_wr_vld_reg  <= sw_wr_vld_next;
            acc_cnt_reg    <= acc_cnt_next;
            qa_reg         <= qa_next;
            qb_reg         <= qb_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sw_wr_node_reg <= sw_wr_node_next;
        sw_wr_leaf_reg <= sw_wr_leaf_next;
        sw_wr_bit_reg  <= sw_wr_bit_next;
        id_reg         <= id_next;
        old_leaf_reg   <= old_leaf_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        sum_reg        <= sum_next;
        walk_node_reg  <= walk_node_next;
        walk_inc_reg   <= walk_inc_next;
        res_above_reg  <= res_above_next;
        res_status_reg <= res_status_next;
        m_above_reg    <= m_above_next;
        m_status_reg   <= m_status_next;
    end

    lsd_stamp_ram #(
        .DEPTH (MAX_ITEMS),
        .DW    (LEAF_W)
    ) u_stamp_ram (
        .clk     (aclk),
        .rd_en   (st_re),
        .rd_addr (st_raddr),
        .rd_data (st_rdata),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata)
    );

    lsd_tree_ram #(
        .DEPTH (2 * TREE_LEAVES),
        .DW    (CNT_W)
    ) u_tree_ram (
        .clk       (aclk),
        .rd_a_en   (ta_en),
        .rd_a_addr (ta_addr),
        .rd_a_data (ta_data),
        .rd_b_en   (tb_en),
        .rd_b_addr (tb_addr),
        .rd_b_data (tb_data),
        .wr_en     (tw_en),
        .wr_addr   (tw_addr),
        .wr_data   (tw_data)
    );

    assign m_valid       = m_valid_reg;
    assign m_items_above = m_above_reg;
    assign m_status      = m_status_reg;

    `ASSERT_IMPL(a_one_tree_writer, aclk, aresetn, sw_wr_vld_reg,
                 state_reg != ST_WALK_WR, "rebuild and walk both write the tree")
    `ASSERT_CLK(a_acc_bound, aclk, aresetn, 32'(acc_cnt_reg) <= MAX_ACCESSES,
                "access count past capacity")
    `ASSERT_IMPL(a_sum_bound, aclk, aresetn, state_reg == ST_FIN,
                 32'(sum_reg) < 32'(item_count_reg), "stack distance not below item count")
    `ASSERT_IMPL(a_acc_step, aclk, aresetn,
                 $past(aresetn) && !$past(cfg_wr_en) && (acc_cnt_reg != $past(acc_cnt_reg)),
                 $past(state_reg) == ST_FIN, "access count moved outside finish")

endmodule
